### rtl/core/bcte_pkg.sv
// ---------------------------------------------------------------------------
// Block chain table engine package
// Shared widths, item kinds, status codes, register indexes and sequencer
// states.
// ---------------------------------------------------------------------------
package bcte_pkg;

    localparam int LINK_W  = 16;
    localparam int IDX_W   = 12;
    localparam int COUNT_W = 13;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BROKEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_END_MARK        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MARK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROHIBITED_MARK = 2'd2;

    localparam logic [LINK_W-1:0] END_MARK_RST        = 16'd1;
    localparam logic [LINK_W-1:0] UNUSED_MARK_RST     = 16'd0;
    localparam logic [LINK_W-1:0] PROHIBITED_MARK_RST = 16'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_APP,
        S_FR_RD,
        S_FR_CHK
    } t_state;

endpackage

### rtl/core/bcte_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ---------------------------------------------------------------------------
module bcte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/block_chain_table_engine.sv
// ---------------------------------------------------------------------------
// Block chain table engine
// Table of next-block links with write, read, run append and chain free.
// ---------------------------------------------------------------------------
// Steps: a write stores the entry; a read fetches it; an append links any old
// tail, then writes each run entry in turn, the last with the end mark; a free
// reads, clears and follows each entry; out-of-range items never leave idle.
// One item at a time: the next item is taken in the cycle its predecessor's
// result shows. Results cannot stall. Reset idles the sequencer and loads the
// mark registers' defaults; table contents stay undefined until written.
module block_chain_table_engine #(
    parameter int unsigned TABLE_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bcte_pkg::KIND_W-1:0]        i_kind,
    input  logic [bcte_pkg::IDX_W-1:0]         i_entry_index,
    input  logic [bcte_pkg::LINK_W-1:0]        i_entry_value,
    input  logic                               i_has_prev,
    input  logic [bcte_pkg::IDX_W-1:0]         i_start_block,
    input  logic [bcte_pkg::COUNT_W-1:0]       i_block_count,
    input  logic                               i_cfg_we,
    input  logic [bcte_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bcte_pkg::LINK_W-1:0]        i_cfg_data,
    output logic                               o_done,
    output logic [bcte_pkg::LINK_W-1:0]        o_read_value,
    output logic [bcte_pkg::IDX_W-1:0]         o_head_block,
    output logic [bcte_pkg::IDX_W-1:0]         o_tail_block,
    output logic [bcte_pkg::STAT_W-1:0]        o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);

    bcte_pkg::t_state r_state, n_state;

    logic [bcte_pkg::LINK_W-1:0] r_end_mark, r_unused_mark, r_prohib_mark;
    logic [bcte_pkg::LINK_W-1:0] r_ptr, n_ptr;
    logic [bcte_pkg::LINK_W-1:0] r_last, n_last;
    logic                        r_done, n_done;
    logic [bcte_pkg::LINK_W-1:0] r_read_value, n_read_value;
    logic [bcte_pkg::IDX_W-1:0]  r_head, n_head;
    logic [bcte_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic [bcte_pkg::STAT_W-1:0] r_status, n_status;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [bcte_pkg::LINK_W-1:0] ram_wdata;
    logic [bcte_pkg::LINK_W-1:0] ram_rdata;

    logic                         idx_ok;
    logic [bcte_pkg::COUNT_W-1:0] count_eff;
    logic [bcte_pkg::LINK_W-1:0]  app_last;
    logic                         app_ok;
    logic [bcte_pkg::LINK_W-1:0]  ptr_inc;

    bcte_ram #(
        .WIDTH (bcte_pkg::LINK_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_ok    = 32'(i_entry_index) < TABLE_DEPTH;
    assign count_eff = (i_block_count == '0) ? bcte_pkg::COUNT_W'(1) : i_block_count;
    assign app_last  = bcte_pkg::LINK_W'(i_start_block) + bcte_pkg::LINK_W'(count_eff)
                       - bcte_pkg::LINK_W'(1);
    assign app_ok    = (32'(app_last) < TABLE_DEPTH) && (!i_has_prev || idx_ok);
    assign ptr_inc   = r_ptr + bcte_pkg::LINK_W'(1);

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_last       = r_last;
        n_done       = 1'b0;
        n_read_value = r_read_value;
        n_head       = r_head;
        n_tail       = r_tail;
        n_status     = r_status;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_ptr);
        ram_wdata    = r_unused_mark;
        ram_raddr    = AW'(r_ptr);

        case (r_state)
            bcte_pkg::S_IDLE: begin
                ram_raddr = AW'(i_entry_index);
                if (start) begin
                    n_read_value = '0;
                    n_head       = '0;
                    n_tail       = '0;
                    n_status     = bcte_pkg::ST_RANGE;
                    case (i_kind)
                        bcte_pkg::KIND_WRITE: begin
                            n_done = 1'b1;
                            if (idx_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(i_entry_index);
                                ram_wdata = i_entry_value;
                                n_status  = bcte_pkg::ST_OK;
                            end
                        end
                        bcte_pkg::KIND_READ: begin
                            if (idx_ok) begin
                                n_state = bcte_pkg::S_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        bcte_pkg::KIND_APPEND: begin
                            if (app_ok) begin
                                // link the old tail in now, if there is one; the run follows
                                ram_we    = i_has_prev;
                                ram_waddr = AW'(i_entry_index);
                                ram_wdata = bcte_pkg::LINK_W'(i_start_block);
                                n_ptr     = bcte_pkg::LINK_W'(i_start_block);
                                n_last    = app_last;
                                n_head    = i_has_prev ? '0 : i_start_block;
                                n_tail    = app_last[bcte_pkg::IDX_W-1:0];
                                n_status  = bcte_pkg::ST_OK;
                                n_state   = bcte_pkg::S_APP;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        bcte_pkg::KIND_FREE: begin
                            if (idx_ok) begin
                                n_ptr   = bcte_pkg::LINK_W'(i_entry_index);
                                n_state = bcte_pkg::S_FR_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            bcte_pkg::S_RD: begin
                n_read_value = ram_rdata;
                n_status     = bcte_pkg::ST_OK;
                n_done       = 1'b1;
                n_state      = bcte_pkg::S_IDLE;
            end
            bcte_pkg::S_APP: begin
                ram_we = 1'b1;
                if (r_ptr == r_last) begin
                    ram_wdata = r_end_mark;
                    n_done    = 1'b1;
                    n_state   = bcte_pkg::S_IDLE;
                end else begin
                    ram_wdata = ptr_inc;
                    n_ptr     = ptr_inc;
                end
            end
            bcte_pkg::S_FR_RD: begin
                n_state = bcte_pkg::S_FR_CHK;
            end
            bcte_pkg::S_FR_CHK: begin
                // entry is cleared whatever the link held
                ram_we    = 1'b1;
                ram_wdata = r_unused_mark;
                if (ram_rdata == r_end_mark) begin
                    n_status = bcte_pkg::ST_OK;
                    n_done   = 1'b1;
                    n_state  = bcte_pkg::S_IDLE;
                end else if (ram_rdata == r_unused_mark || ram_rdata == r_prohib_mark) begin
                    n_status = bcte_pkg::ST_BROKEN;
                    n_done   = 1'b1;
                    n_state  = bcte_pkg::S_IDLE;
                end else if (32'(ram_rdata) >= TABLE_DEPTH) begin
                    n_status = bcte_pkg::ST_RANGE;
                    n_done   = 1'b1;
                    n_state  = bcte_pkg::S_IDLE;
                end else begin
                    n_ptr   = ram_rdata;
                    n_state = bcte_pkg::S_FR_RD;
                end
            end
            default: begin
                n_state = bcte_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcte_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_ptr        <= n_ptr;
        r_last       <= n_last;
        r_read_value <= n_read_value;
        r_head       <= n_head;
        r_tail       <= n_tail;
        r_status     <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_mark    <= bcte_pkg::END_MARK_RST;
            r_unused_mark <= bcte_pkg::UNUSED_MARK_RST;
            r_prohib_mark <= bcte_pkg::PROHIBITED_MARK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bcte_pkg::CFG_END_MARK:        r_end_mark    <= i_cfg_data;
                bcte_pkg::CFG_UNUSED_MARK:     r_unused_mark <= i_cfg_data;
                bcte_pkg::CFG_PROHIBITED_MARK: r_prohib_mark <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy         = (r_state != bcte_pkg::S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = r_read_value;
    assign o_head_block = r_head;
    assign o_tail_block = r_tail;
    assign o_status     = r_status;

endmodule

### rtl/core/bcte_checker.sv
// ---------------------------------------------------------------------------
// Block chain table engine checker
// Port-level checks on command timing and result contents.
// ---------------------------------------------------------------------------
module bcte_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [bcte_pkg::KIND_W-1:0]    i_kind,
    input logic                           o_done,
    input logic [bcte_pkg::LINK_W-1:0]    o_read_value,
    input logic [bcte_pkg::IDX_W-1:0]     o_head_block,
    input logic [bcte_pkg::IDX_W-1:0]     o_tail_block,
    input logic [bcte_pkg::STAT_W-1:0]    o_status
);

    // a result transfer always leaves the engine free for the next command
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == bcte_pkg::KIND_WRITE) |=> (o_done && !busy))
        else $error("write did not complete in one cycle");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == bcte_pkg::KIND_READ) |=> (o_done or (busy ##1 o_done)))
        else $error("read result late");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == bcte_pkg::ST_OK || o_status == bcte_pkg::ST_BROKEN ||
                    o_status == bcte_pkg::ST_RANGE))
        else $error("bad status code");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_read_value != '0) |-> (o_head_block == '0 && o_tail_block == '0))
        else $error("read result carries block numbers");

endmodule

bind block_chain_table_engine bcte_checker u_bcte_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_kind       (i_kind),
    .o_done       (o_done),
    .o_read_value (o_read_value),
    .o_head_block (o_head_block),
    .o_tail_block (o_tail_block),
    .o_status     (o_status)
);
